// ===== rtl/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies expression in the same cycle, checked on clk, off in reset
`define ASSERT_IMPLY(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// condition implies expression in the next cycle
`define ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/ohash_pkg.sv =====
// package: types, widths and codes of the open addressing hash table
`default_nettype none

package ohash_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int KEY_W       = 31;
	localparam int SIZE_W      = 7;
	localparam int MARK_W      = 2;
	localparam int ENTRY_W     = MARK_W + KEY_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = SIZE_W;
	localparam int BCNT_W      = $clog2(KEY_W);
	localparam int R7_W        = 3;

	// second hash divisor
	localparam logic [R7_W-1:0] HASH_PRIME = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b1;

	// probe modes
	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_QUAD   = 2'd1;
	localparam logic [1:0] MODE_DOUBLE = 2'd2;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_DEL   = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_DUMP   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_EXISTS    = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_DELETED   = 3'd3,
		STAT_ABSENT    = 3'd4,
		STAT_FOUND     = 3'd5,
		STAT_NOT_FOUND = 3'd6,
		STAT_DUMP      = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_REDC,
		S_RD,
		S_CHK,
		S_DRD,
		S_DCHK
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/ohash_ram.sv =====
// generic single port write, registered read ram
`default_nettype none

module ohash_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64,
	localparam int AddrW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ohash_modstep.sv =====
// shared compare-subtract unit: one restoring division step against the table size
`default_nettype none

module ohash_modstep (
	input  wire logic [ohash_pkg::SIZE_W-1:0] a,
	input  wire logic [ohash_pkg::SIZE_W-1:0] modulus,
	input  wire logic [ohash_pkg::R7_W-1:0]   r7_in,
	input  wire logic                         bit_in,
	output logic      [ohash_pkg::SIZE_W-1:0] res,
	output logic      [ohash_pkg::R7_W-1:0]   r7_out
);

	logic [ohash_pkg::R7_W:0] t7;

	// one subtract reduces a only when a is below twice the modulus
	assign res = (a >= modulus) ? (a - modulus) : a;

	// running key mod 7, one key bit per step
	assign t7     = {r7_in, bit_in};
	assign r7_out = (t7 >= {1'b0, ohash_pkg::HASH_PRIME})
		? ohash_pkg::R7_W'(t7 - {1'b0, ohash_pkg::HASH_PRIME})
		: ohash_pkg::R7_W'(t7);

endmodule

`default_nettype wire

// ===== rtl/open_addressing_hash_table.sv =====
// top level: open addressing hash table with linear, quadratic and double hash probing
`default_nettype none

// request channel: req_valid/req_stall carry action and key; a transfer happens when
// req_valid is high and req_stall is low. req_stall is high from the transfer until the
// item's last result is loaded into the response register.
// response channel: rsp_valid/rsp_stall carry status, slot, value and last; the response
// register holds its payload while rsp_stall is high and the sequencer waits on it.
// config: cfg_we writes probe_mode (index 0) or table_size (index 1); the user must write
// only while idle, the block itself does not enforce it. insert, delete, find: key mod
// size (one quotient bit per cycle in the shared compare-subtract unit), then reducing
// the probe increment below the table size, then probes, each a ram read and then a
// check, up to the effective table size in probes; one result. dump: every slot up to
// the effective table size is read, then checked; one result per slot, last on the final
// one. the registered memory read port sets this read-then-check step of probe and dump.
// reset: probe_mode linear, table_size 64, all slots empty through per-slot valid
// bits, so there is no clearing pass and the block takes requests right away.
`include "assert_macros.svh"

module open_addressing_hash_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration port
	input  wire logic                                cfg_we,
	input  wire logic [ohash_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ohash_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request channel
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire logic [1:0]                          action,
	input  wire logic [ohash_pkg::KEY_W-1:0]         key,
	// response channel
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic [2:0]                               status,
	output logic [ohash_pkg::ADDR_W-1:0]             slot,
	output logic [ohash_pkg::KEY_W-1:0]              value,
	output logic                                     last
);

	// sequencer
	ohash_pkg::state_t state_q, state_d;

	// configuration
	logic [1:0]                   probe_mode_q;
	logic [ohash_pkg::SIZE_W-1:0] table_size_q;
	logic [ohash_pkg::SIZE_W-1:0] size_eff;

	// item registers
	ohash_pkg::action_t            action_q;
	logic [ohash_pkg::KEY_W-1:0]   key_q;
	logic [ohash_pkg::BCNT_W-1:0]  bcnt_q;
	logic [ohash_pkg::ADDR_W-1:0]  rem_q;
	logic [ohash_pkg::R7_W-1:0]    r7_q;
	logic [ohash_pkg::ADDR_W-1:0]  cm_q;
	logic [ohash_pkg::ADDR_W-1:0]  cur_q;
	logic [ohash_pkg::SIZE_W-1:0]  pcnt_q;
	logic                          free_found_q;
	logic [ohash_pkg::ADDR_W-1:0]  free_slot_q;
	logic [ohash_pkg::ADDR_W-1:0]  dcnt_q;
	logic [ohash_pkg::TABLE_DEPTH-1:0] vld_q;

	// response register
	logic                          rsp_valid_q;
	ohash_pkg::status_t            status_q;
	logic [ohash_pkg::ADDR_W-1:0]  slot_q;
	logic [ohash_pkg::KEY_W-1:0]   value_q;
	logic                          last_q;

	// shared unit
	logic [ohash_pkg::SIZE_W-1:0]  unit_a;
	logic [ohash_pkg::SIZE_W-1:0]  unit_res;
	logic [ohash_pkg::R7_W-1:0]    unit_r7;

	// ram
	logic                          ram_we;
	logic [ohash_pkg::ADDR_W-1:0]  ram_waddr;
	logic [ohash_pkg::ENTRY_W-1:0] ram_wdata;
	logic                          ram_re;
	logic [ohash_pkg::ADDR_W-1:0]  ram_raddr;
	logic [ohash_pkg::ENTRY_W-1:0] ram_rdata;

	// probe check
	logic [ohash_pkg::ADDR_W-1:0]  rd_idx;
	ohash_pkg::mark_t              rd_mark;
	logic [ohash_pkg::KEY_W-1:0]   rd_key;
	logic                          rd_used;
	logic                          hit;
	logic                          stop_empty;
	logic                          probes_done;
	logic                          chk_term;
	logic                          free_now;
	logic [ohash_pkg::ADDR_W-1:0]  free_slot_now;
	logic                          dump_last;
	logic                          out_free;
	logic [ohash_pkg::ADDR_W-1:0]  cm_init;
	logic [ohash_pkg::SIZE_W-1:0]  quad_t;
	logic [ohash_pkg::ADDR_W-1:0]  quad_next;
	logic                          req_xfer;

	// output load
	logic                          out_load;
	ohash_pkg::status_t            out_status;
	logic [ohash_pkg::ADDR_W-1:0]  out_slot;
	logic [ohash_pkg::KEY_W-1:0]   out_value;
	logic                          out_last;
	logic                          vld_set;
	logic                          vld_clr;

	// table size 0 acts as 1, above the depth acts as the depth
	always_comb begin
		if (table_size_q == '0) begin
			size_eff = ohash_pkg::SIZE_W'(1);
		end else if (table_size_q > ohash_pkg::SIZE_W'(ohash_pkg::TABLE_DEPTH)) begin
			size_eff = ohash_pkg::SIZE_W'(ohash_pkg::TABLE_DEPTH);
		end else begin
			size_eff = table_size_q;
		end
	end

	assign req_stall = (state_q != ohash_pkg::S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// shared compare-subtract unit, operand picked by the sequencer
	always_comb begin
		unique case (state_q)
			ohash_pkg::S_DIV:  unit_a = {rem_q, key_q[bcnt_q]};
			ohash_pkg::S_REDC: unit_a = {1'b0, cm_q};
			default:           unit_a = {1'b0, cur_q} + {1'b0, cm_q};
		endcase
	end

	ohash_modstep u_modstep (
		.a       (unit_a),
		.modulus (size_eff),
		.r7_in   (r7_q),
		.bit_in  (key_q[bcnt_q]),
		.res     (unit_res),
		.r7_out  (unit_r7)
	);

	// first increment: 1 for linear and quadratic, 7 - key mod 7 for double hashing
	always_comb begin
		if (probe_mode_q == ohash_pkg::MODE_DOUBLE) begin
			cm_init = ohash_pkg::ADDR_W'(ohash_pkg::HASH_PRIME - unit_r7);
		end else begin
			cm_init = ohash_pkg::ADDR_W'(1);
		end
	end

	// quadratic increment grows by 2 each probe, kept reduced
	assign quad_t = {1'b0, cm_q} + ohash_pkg::SIZE_W'(2);
	always_comb begin
		if (size_eff == ohash_pkg::SIZE_W'(1)) begin
			quad_next = '0;
		end else if (quad_t >= size_eff) begin
			quad_next = ohash_pkg::ADDR_W'(quad_t - size_eff);
		end else begin
			quad_next = ohash_pkg::ADDR_W'(quad_t);
		end
	end

	// slot content of the last read; a slot never written reads as empty
	assign rd_idx  = (state_q == ohash_pkg::S_DCHK) ? dcnt_q : cur_q;
	assign rd_mark = vld_q[rd_idx]
		? ohash_pkg::mark_t'(ram_rdata[ohash_pkg::ENTRY_W-1 -: ohash_pkg::MARK_W])
		: ohash_pkg::MARK_EMPTY;
	assign rd_key  = ram_rdata[ohash_pkg::KEY_W-1:0];
	assign rd_used = (rd_mark == ohash_pkg::MARK_USED);

	assign hit           = rd_used && (rd_key == key_q);
	assign stop_empty    = !rd_used && (rd_mark != ohash_pkg::MARK_DEL);
	assign probes_done   = (pcnt_q + ohash_pkg::SIZE_W'(1)) == size_eff;
	assign chk_term      = hit || stop_empty || probes_done;
	assign free_now      = free_found_q || !rd_used;
	assign free_slot_now = free_found_q ? free_slot_q : cur_q;
	assign dump_last     = ({1'b0, dcnt_q} + ohash_pkg::SIZE_W'(1)) == size_eff;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ohash_pkg::S_IDLE: begin
				if (req_xfer) begin
					state_d = (ohash_pkg::action_t'(action) == ohash_pkg::ACT_DUMP)
						? ohash_pkg::S_DRD : ohash_pkg::S_DIV;
				end
			end
			ohash_pkg::S_DIV: begin
				if (bcnt_q == '0) begin
					state_d = ohash_pkg::S_REDC;
				end
			end
			ohash_pkg::S_REDC: begin
				if (unit_res < size_eff) begin
					state_d = ohash_pkg::S_RD;
				end
			end
			ohash_pkg::S_RD: begin
				state_d = ohash_pkg::S_CHK;
			end
			ohash_pkg::S_CHK: begin
				if (!chk_term) begin
					state_d = ohash_pkg::S_RD;
				end else if (out_free) begin
					state_d = ohash_pkg::S_IDLE;
				end
			end
			ohash_pkg::S_DRD: begin
				state_d = ohash_pkg::S_DCHK;
			end
			ohash_pkg::S_DCHK: begin
				if (out_free) begin
					state_d = dump_last ? ohash_pkg::S_IDLE : ohash_pkg::S_DRD;
				end
			end
			default: begin
				state_d = ohash_pkg::S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer: ram port, valid bits, response load
	always_comb begin
		ram_re     = 1'b0;
		ram_raddr  = cur_q;
		ram_we     = 1'b0;
		ram_waddr  = free_slot_now;
		ram_wdata  = {ohash_pkg::MARK_USED, key_q};
		vld_set    = 1'b0;
		vld_clr    = 1'b0;
		out_load   = 1'b0;
		out_status = ohash_pkg::STAT_NOT_FOUND;
		out_slot   = '0;
		out_value  = key_q;
		out_last   = 1'b1;
		unique case (state_q)
			ohash_pkg::S_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cur_q;
			end
			ohash_pkg::S_DRD: begin
				ram_re    = 1'b1;
				ram_raddr = dcnt_q;
			end
			ohash_pkg::S_CHK: begin
				if (chk_term && out_free) begin
					out_load = 1'b1;
					unique case (action_q)
						ohash_pkg::ACT_INSERT: begin
							if (hit) begin
								out_status = ohash_pkg::STAT_EXISTS;
								out_slot   = cur_q;
							end else if (free_now) begin
								// first free slot on the probe path takes the key
								out_status = ohash_pkg::STAT_INSERTED;
								out_slot   = free_slot_now;
								ram_we     = 1'b1;
								ram_waddr  = free_slot_now;
								ram_wdata  = {ohash_pkg::MARK_USED, key_q};
								vld_set    = 1'b1;
							end else begin
								out_status = ohash_pkg::STAT_FULL;
							end
						end
						ohash_pkg::ACT_DELETE: begin
							if (hit) begin
								// leave a tombstone so later keys stay reachable
								out_status = ohash_pkg::STAT_DELETED;
								out_slot   = cur_q;
								ram_we     = 1'b1;
								ram_waddr  = cur_q;
								ram_wdata  = {ohash_pkg::MARK_DEL, key_q};
								vld_set    = 1'b1;
							end else begin
								out_status = ohash_pkg::STAT_ABSENT;
							end
						end
						default: begin
							if (hit) begin
								out_status = ohash_pkg::STAT_FOUND;
								out_slot   = cur_q;
							end else begin
								out_status = ohash_pkg::STAT_NOT_FOUND;
							end
						end
					endcase
				end
			end
			ohash_pkg::S_DCHK: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = ohash_pkg::STAT_DUMP;
					out_slot   = dcnt_q;
					out_value  = rd_used ? rd_key : '0;
					out_last   = dump_last;
					// tombstones become empty by dropping the valid bit
					vld_clr    = !rd_used;
				end
			end
			default: begin
			end
		endcase
	end

	ohash_ram #(
		.WIDTH (ohash_pkg::ENTRY_W),
		.DEPTH (ohash_pkg::TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ohash_pkg::S_IDLE;
			probe_mode_q <= ohash_pkg::MODE_LINEAR;
			table_size_q <= ohash_pkg::SIZE_W'(ohash_pkg::TABLE_DEPTH);
			vld_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					ohash_pkg::REG_PROBE_MODE: probe_mode_q <= cfg_data[1:0];
					ohash_pkg::REG_TABLE_SIZE: table_size_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (vld_set) begin
				vld_q[ram_waddr] <= 1'b1;
			end else if (vld_clr) begin
				vld_q[dcnt_q] <= 1'b0;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status;
			slot_q   <= out_slot;
			value_q  <= out_value;
			last_q   <= out_last;
		end
		case (state_q)
			ohash_pkg::S_IDLE: begin
				action_q     <= ohash_pkg::action_t'(action);
				key_q        <= key;
				bcnt_q       <= ohash_pkg::BCNT_W'(ohash_pkg::KEY_W - 1);
				rem_q        <= '0;
				r7_q         <= '0;
				dcnt_q       <= '0;
				pcnt_q       <= '0;
				free_found_q <= 1'b0;
			end
			ohash_pkg::S_DIV: begin
				// key mod size, msb first
				rem_q  <= ohash_pkg::ADDR_W'(unit_res);
				r7_q   <= unit_r7;
				bcnt_q <= bcnt_q - ohash_pkg::BCNT_W'(1);
				if (bcnt_q == '0) begin
					cur_q <= ohash_pkg::ADDR_W'(unit_res);
					cm_q  <= cm_init;
				end
			end
			ohash_pkg::S_REDC: begin
				cm_q <= ohash_pkg::ADDR_W'(unit_res);
			end
			ohash_pkg::S_CHK: begin
				if (!chk_term) begin
					pcnt_q <= pcnt_q + ohash_pkg::SIZE_W'(1);
					cur_q  <= ohash_pkg::ADDR_W'(unit_res);
					if (probe_mode_q == ohash_pkg::MODE_QUAD) begin
						cm_q <= quad_next;
					end
					if (!free_found_q && !rd_used) begin
						free_found_q <= 1'b1;
						free_slot_q  <= cur_q;
					end
				end
			end
			ohash_pkg::S_DCHK: begin
				if (out_free) begin
					dcnt_q <= dcnt_q + ohash_pkg::ADDR_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign value     = value_q;
	assign last      = last_q;

	// probe increment stays reduced below the table size while probing
	`ASSERT_IMPLY(a_cm_reduced, (state_q == ohash_pkg::S_RD || state_q == ohash_pkg::S_CHK), ({1'b0, cm_q} < size_eff), "probe increment not reduced")
	// probed slot always lies inside the table in use
	`ASSERT_IMPLY(a_cur_in_table, (state_q == ohash_pkg::S_RD || state_q == ohash_pkg::S_CHK), ({1'b0, cur_q} < size_eff), "probe slot outside table")
	// every result other than a dump entry ends its item
	`ASSERT_IMPLY(a_single_last, (rsp_valid_q && status_q != ohash_pkg::STAT_DUMP), last_q, "single result without last")
	// the final dump entry returns the sequencer to idle
	`ASSERT_NEXT(a_dump_done, (state_q == ohash_pkg::S_DCHK && out_load && out_last), (state_q == ohash_pkg::S_IDLE), "dump did not finish")

endmodule

`default_nettype wire

// ===== tb/open_addressing_hash_table_tb.sv =====
// testbench for the open addressing hash table: directed and random traffic with a scoreboard
`default_nettype none

module open_addressing_hash_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ohash_pkg::*;

	// cycles with no transfer on either channel before the run is declared hung;
	// the slowest item is a full probe walk, plus sender gaps and response stalls
	localparam int STUCK_LIMIT = 5000;
	localparam int PHASE_ITEMS = 38;
	localparam int KEY_POOL    = 16;

	// one response beat as the table should produce it
	typedef struct {
		status_t               st;
		logic [ADDR_W-1:0]     sl;
		logic [KEY_W-1:0]      val;
		logic                  lst;
	} table_result_t;

	// shadow of the slot store plus the queue of responses still owed
	class hash_scoreboard;
		logic [1:0]        probe_mode;
		logic [SIZE_W-1:0] table_size;
		logic [KEY_W-1:0]  slot_key[TABLE_DEPTH];
		mark_t             slot_mark[TABLE_DEPTH];
		table_result_t     owed_q[$];
		int                errors;

		function new();
			probe_mode = MODE_LINEAR;
			table_size = SIZE_W'(TABLE_DEPTH);
			errors = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_key[i] = '0;
				slot_mark[i] = MARK_EMPTY;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_PROBE_MODE)
				probe_mode = data[1:0];
			else
				table_size = data;
		endfunction

		// zero acts as one, oversize clamps to the physical depth
		function int unsigned active_size();
			if (table_size == 0)
				return 1;
			if (table_size > TABLE_DEPTH)
				return TABLE_DEPTH;
			return table_size;
		endfunction

		function int unsigned probe_at(logic [KEY_W-1:0] k, int unsigned i, int unsigned n);
			longint unsigned step;
			if (probe_mode == MODE_QUAD)
				step = longint'(i) * i;
			else if (probe_mode == MODE_DOUBLE)
				step = longint'(i) * (HASH_PRIME - (k % HASH_PRIME));
			else
				step = i;
			return int'((longint'(k) + step) % n);
		endfunction

		// walks past tombstones, stops at an empty slot or after n probes
		function bit lookup_key(logic [KEY_W-1:0] k, int unsigned n, output int unsigned where);
			int unsigned s;
			where = 0;
			for (int unsigned i = 0; i < n; i++) begin
				s = probe_at(k, i, n);
				if (slot_mark[s] == MARK_USED) begin
					if (slot_key[s] == k) begin
						where = s;
						return 1;
					end
				end else if (slot_mark[s] != MARK_DEL) begin
					return 0;
				end
			end
			return 0;
		endfunction

		function void owe(status_t st, int unsigned sl, logic [KEY_W-1:0] v, bit lst);
			table_result_t r;
			r.st = st;
			r.sl = ADDR_W'(sl);
			r.val = v;
			r.lst = lst;
			owed_q.push_back(r);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void note_request(action_t act, logic [KEY_W-1:0] k);
			int unsigned n;
			int unsigned where;
			int unsigned s;
			bit placed;
			logic [KEY_W-1:0] v;
			n = active_size();
			case (act)
				ACT_INSERT: begin
					if (lookup_key(k, n, where)) begin
						owe(STAT_EXISTS, where, k, 1'b1);
					end else begin
						placed = 0;
						for (int unsigned i = 0; i < n && !placed; i++) begin
							s = probe_at(k, i, n);
							if (slot_mark[s] != MARK_USED) begin
								slot_key[s] = k;
								slot_mark[s] = MARK_USED;
								owe(STAT_INSERTED, s, k, 1'b1);
								placed = 1;
							end
						end
						if (!placed)
							owe(STAT_FULL, 0, k, 1'b1);
					end
				end
				ACT_DELETE: begin
					if (lookup_key(k, n, where)) begin
						slot_mark[where] = MARK_DEL;
						owe(STAT_DELETED, where, k, 1'b1);
					end else begin
						owe(STAT_ABSENT, 0, k, 1'b1);
					end
				end
				ACT_FIND: begin
					if (lookup_key(k, n, where))
						owe(STAT_FOUND, where, k, 1'b1);
					else
						owe(STAT_NOT_FOUND, 0, k, 1'b1);
				end
				default: begin
					// dump also scrubs tombstones
					for (int unsigned i = 0; i < n; i++) begin
						v = '0;
						if (slot_mark[i] == MARK_USED) begin
							v = slot_key[i];
						end else begin
							slot_mark[i] = MARK_EMPTY;
							slot_key[i] = '0;
						end
						owe(STAT_DUMP, i, v, i + 1 == n);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 100)
				$display("mismatch: %s", msg);
		endtask

		task check_result(logic [2:0] st, logic [ADDR_W-1:0] sl, logic [KEY_W-1:0] v, logic lst);
			table_result_t e;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected response stat %0d slot %0d value %0h",
					st, sl, v));
				return;
			end
			e = owed_q.pop_front();
			if (st !== e.st)
				report_mismatch($sformatf("stat %0d, wanted %0d (%s)", st, e.st, e.st.name()));
			if (sl !== e.sl)
				report_mismatch($sformatf("slot %0d, wanted %0d (%s)", sl, e.sl, e.st.name()));
			if (v !== e.val)
				report_mismatch($sformatf("value %0h, wanted %0h (%s slot %0d)",
					v, e.val, e.st.name(), e.sl));
			if (lst !== e.lst)
				report_mismatch($sformatf("last %0b, wanted %0b (%s slot %0d)",
					lst, e.lst, e.st.name(), e.sl));
		endtask
	endclass

	// every input starts at a known value
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [1:0]            action    = '0;
	logic [KEY_W-1:0]      key       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [2:0]            status;
	logic [ADDR_W-1:0]     slot;
	logic [KEY_W-1:0]      value;
	logic                  last;

	// quiet stretch: neither side idles
	bit quiet = 1'b0;
	int stuck_cycles = 0;

	hash_scoreboard sb = new();

	open_addressing_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.slot      (slot),
		.value     (value),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// response side back-pressure, stalled at random with a chance of 23 in a hundred
	always @(negedge clk) begin
		if (quiet)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < 23);
	end

	// every response transfer is checked against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(status, slot, value, last);
	end

	// hang detection: cycles without any transfer on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one request transfer; called and returns at a falling edge, valid left high so a
	// following item goes out without a bubble
	task automatic send_item(action_t act, logic [KEY_W-1:0] k);
		while (!quiet && $urandom_range(0, 99) < 23) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		key <= k;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(act, k);
		@(negedge clk);
	endtask

	// sender holds off until every owed response has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() > 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// registers change only with the table idle; upper data bits of the mode write are noise
	task automatic set_table(logic [1:0] mode, logic [SIZE_W-1:0] size);
		drain();
		repeat (4) @(negedge clk);
		write_reg(REG_PROBE_MODE, {5'($urandom_range(0, 31)), mode});
		write_reg(REG_TABLE_SIZE, size);
	endtask

	// random traffic over a small key pool so inserts, finds and deletes collide and hit
	task automatic run_phase(int n_items);
		logic [KEY_W-1:0] pool[KEY_POOL];
		logic [KEY_W-1:0] k;
		int unsigned n;
		int pick;
		n = sb.active_size();
		for (int i = 0; i < KEY_POOL; i++) begin
			if (i < KEY_POOL / 2)
				pool[i] = KEY_W'($urandom_range(0, 4 * n + 8));
			else
				pool[i] = KEY_W'($urandom);
		end
		for (int j = 0; j < n_items; j++) begin
			if ($urandom_range(0, 4) == 0)
				k = KEY_W'($urandom);
			else
				k = pool[$urandom_range(0, KEY_POOL - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_item(ACT_INSERT, k);
			else if (pick < 65)
				send_item(ACT_DELETE, k);
			else if (pick < 95)
				send_item(ACT_FIND, k);
			else
				send_item(ACT_DUMP, k);
			// occasional full drain so the block sees a cold start mid-phase
			if ($urandom_range(0, 29) == 0)
				drain();
		end
	endtask

	initial begin
		logic [1:0]        modes[8];
		logic [SIZE_W-1:0] sizes[8];
		modes = '{MODE_QUAD, MODE_DOUBLE, MODE_LINEAR, 2'd3,
			MODE_DOUBLE, MODE_QUAD, MODE_LINEAR, MODE_DOUBLE};
		sizes = '{7'd13, 7'd64, 7'd1, 7'd0, 7'd17, 7'd127, 7'd8,
			SIZE_W'($urandom_range(2, 63))};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: linear, 64 slots; collisions, tombstones and the top key
		send_item(ACT_INSERT, '0);
		send_item(ACT_INSERT, KEY_W'(64));
		send_item(ACT_INSERT, '1);
		send_item(ACT_INSERT, '0);
		send_item(ACT_FIND, KEY_W'(64));
		send_item(ACT_DELETE, '0);
		send_item(ACT_FIND, KEY_W'(64));
		send_item(ACT_DELETE, '0);
		send_item(ACT_FIND, KEY_W'(128));
		send_item(ACT_INSERT, KEY_W'(128));
		send_item(ACT_DUMP, '0);

		// shrink to four slots, quadratic: cycling offsets report full, top slot hidden
		set_table(MODE_QUAD, 7'd4);
		send_item(ACT_INSERT, KEY_W'(5));
		send_item(ACT_INSERT, KEY_W'(9));
		send_item(ACT_FIND, '1);

		// oversize clamps to full depth, double hashing; hidden entry visible again
		set_table(MODE_DOUBLE, 7'd127);
		send_item(ACT_FIND, '1);
		send_item(ACT_INSERT, KEY_W'(7));
		send_item(ACT_INSERT, KEY_W'(71));
		send_item(ACT_DUMP, '1);

		// unused mode code and zero size: one slot, linear
		set_table(2'd3, 7'd0);
		send_item(ACT_INSERT, KEY_W'(3));
		send_item(ACT_FIND, KEY_W'(128));
		send_item(ACT_DELETE, KEY_W'(128));
		send_item(ACT_INSERT, KEY_W'(3));
		send_item(ACT_DUMP, KEY_W'($urandom));

		for (int p = 0; p < 8; p++) begin
			set_table(modes[p], sizes[p]);
			quiet = (p == 6);
			run_phase(PHASE_ITEMS);
		end
		quiet = 1'b0;

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/ohash_pkg.sv
rtl/ohash_ram.sv
rtl/ohash_modstep.sv
rtl/open_addressing_hash_table.sv
tb/open_addressing_hash_table_tb.sv
